[design/rrc_pkg.sv]
// Shared types and constants for the read request coalescer.
package rrc_pkg;

    localparam int MAX_BLOCKS_DEF = 32;
    localparam int POS_W = 48;
    localparam int LEN_W = 24;
    localparam int SUM_W = 29;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_ADDED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RUN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HIT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MISS = 3'd5;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Contents of one cell of the sorted chain.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic [SUM_W-1:0] off;
    } cell_data_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic             insert;
        logic             rotate;
        logic             wr_off;
        logic [POS_W-1:0] new_pos;
        logic [LEN_W-1:0] new_len;
        logic [SUM_W-1:0] new_off;
    } cell_cmd_t;

endpackage

[design/read_request_coalescer_top.sv]
// Top level of the read request coalescer: cell chain, scan sequencer and result register.
//
// Blocks are kept sorted by position as they are added, in a chain of cells
// that shift toward the tail to open a slot, so an add completes without a scan and its
// single result item appears on the cycle after it. A lookup rotates the listed
// blocks once through the head cell, one block per cycle, comparing each with
// the key; the first lookup after any add also assigns buffer offsets and emits
// merged run items during that same rotation, the last run in a flush state
// after it. A lookup holds busy through the scan, the flush state when runs are
// emitted and the reply state; on an empty list it goes straight to the reply.
// Result items are shown for one cycle with valid high and cannot be stalled;
// the final item caused by an input item carries last.
module read_request_coalescer_top
    import rrc_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [POS_W-1:0]  position,
    input  logic [LEN_W-1:0]  block_len,
    output logic              valid,
    output logic [KIND_W-1:0] kind,
    output logic [POS_W-1:0]  run_pos,
    output logic [SUM_W-1:0]  run_len,
    output logic [SUM_W-1:0]  buf_offset,
    output logic [SUM_W-1:0]  total_bytes,
    output logic              last
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_REPLY = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic sorted_reg, sorted_next;
    logic sorting_reg, sorting_next;
    logic hit_reg, hit_next;
    logic [SUM_W-1:0] hoff_reg, hoff_next;
    logic [POS_W-1:0] key_reg, key_next;
    logic [POS_W-1:0] rpos_reg, rpos_next;
    logic [SUM_W-1:0] rlen_reg, rlen_next;
    logic [POS_W:0] pend_reg, pend_next;
    logic [SUM_W-1:0] acc_reg, acc_next;

    logic valid_reg, valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [POS_W-1:0] opos_reg, opos_next;
    logic [SUM_W-1:0] olen_reg, olen_next;
    logic [SUM_W-1:0] ooff_reg, ooff_next;
    logic last_reg, last_next;

    cell_cmd_t cmd;
    cell_data_t q [MAX_BLOCKS];
    logic ins [MAX_BLOCKS];
    cell_data_t head;
    logic accept;
    logic [POS_W:0] head_end;
    logic [SUM_W-1:0] head_len_x;

    assign head = q[0];
    assign accept = start && (state_reg == ST_IDLE);
    assign head_len_x = SUM_W'(head.len);
    assign head_end = {1'b0, head.pos} + (POS_W+1)'(head.len);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++)
        begin : g_cell
            rrc_cell #(.IDX(gi), .CW(CW)) u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .count    (count_reg),
                .left     (q[(gi > 0) ? gi - 1 : 0]),
                .left_ins ((gi > 0) ? ins[(gi > 0) ? gi - 1 : 0] : 1'b0),
                .right    (q[(gi < MAX_BLOCKS - 1) ? gi + 1 : gi]),
                .head     (head),
                .ins      (ins[gi]),
                .q        (q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next = step_reg;
        total_next = total_reg;
        sorted_next = sorted_reg;
        sorting_next = sorting_reg;
        hit_next = hit_reg;
        hoff_next = hoff_reg;
        key_next = key_reg;
        rpos_next = rpos_reg;
        rlen_next = rlen_reg;
        pend_next = pend_reg;
        acc_next = acc_reg;
        valid_next = 1'b0;
        kind_next = kind_reg;
        opos_next = '0;
        olen_next = '0;
        ooff_next = '0;
        last_next = 1'b0;
        cmd = '0;
        cmd.new_pos = position;
        cmd.new_len = block_len;
        cmd.new_off = acc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_ADD)
                    begin
                        sorted_next = 1'b0;
                        valid_next = 1'b1;
                        last_next = 1'b1;
                        if (position == '0)
                        begin
                            count_next = '0;
                            total_next = '0;
                            kind_next = KIND_RESET;
                        end
                        else if (count_reg >= FULL_COUNT)
                        begin
                            kind_next = KIND_FULL;
                        end
                        else
                        begin
                            cmd.insert = 1'b1;
                            count_next = count_reg + 1'b1;
                            total_next = total_reg + SUM_W'(block_len);
                            kind_next = KIND_ADDED;
                        end
                    end
                    else
                    begin
                        key_next = position;
                        hit_next = 1'b0;
                        hoff_next = '0;
                        step_next = '0;
                        acc_next = '0;
                        if (count_reg == '0)
                        begin
                            sorting_next = 1'b0;
                            state_next = ST_REPLY;
                        end
                        else
                        begin
                            sorting_next = !sorted_reg;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rotate = 1'b1;
                cmd.wr_off = sorting_reg;
                if (head.pos == key_reg)
                begin
                    hit_next = 1'b1;
                    hoff_next = sorting_reg ? acc_reg : head.off;
                end
                if (sorting_reg)
                begin
                    acc_next = acc_reg + head_len_x;
                    pend_next = head_end;
                    if (step_reg == '0)
                    begin
                        rpos_next = head.pos;
                        rlen_next = head_len_x;
                    end
                    else if ({1'b0, head.pos} != pend_reg)
                    begin
                        // A gap closes the current run.
                        valid_next = 1'b1;
                        kind_next = KIND_RUN;
                        opos_next = rpos_reg;
                        olen_next = rlen_reg;
                        rpos_next = head.pos;
                        rlen_next = head_len_x;
                    end
                    else
                    begin
                        rlen_next = rlen_reg + head_len_x;
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == count_reg - 1'b1)
                begin
                    state_next = sorting_reg ? ST_FLUSH : ST_REPLY;
                end
            end
            ST_FLUSH:
            begin
                valid_next = 1'b1;
                kind_next = KIND_RUN;
                opos_next = rpos_reg;
                olen_next = rlen_reg;
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                valid_next = 1'b1;
                last_next = 1'b1;
                kind_next = hit_reg ? KIND_HIT : KIND_MISS;
                ooff_next = hit_reg ? hoff_reg : '0;
                if (sorting_reg)
                begin
                    sorted_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg <= '0;
            total_reg <= '0;
            sorted_reg <= 1'b0;
            sorting_reg <= 1'b0;
            hit_reg <= 1'b0;
            valid_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg <= step_next;
            total_reg <= total_next;
            sorted_reg <= sorted_next;
            sorting_reg <= sorting_next;
            hit_reg <= hit_next;
            valid_reg <= valid_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hoff_reg <= hoff_next;
        key_reg <= key_next;
        rpos_reg <= rpos_next;
        rlen_reg <= rlen_next;
        pend_reg <= pend_next;
        acc_reg <= acc_next;
        kind_reg <= kind_next;
        opos_reg <= opos_next;
        olen_reg <= olen_next;
        ooff_reg <= ooff_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign valid = valid_reg;
    assign kind = kind_reg;
    assign run_pos = opos_reg;
    assign run_len = olen_reg;
    assign buf_offset = ooff_reg;
    assign total_bytes = total_reg;
    assign last = last_reg;

    // The list never holds more blocks than there are cells.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("block count exceeds chain length");

    // Every reply ends a lookup with the closing item on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPLY |=> valid && last)
        else $error("reply state did not deliver the closing item");

    // A run item is always followed later by more items of the same lookup, never last.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_RUN |-> !last && busy)
        else $error("run item marked last or outside a lookup");

    // An accepted add leaves the block idle and answers on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_ADD |=> valid && last && !busy)
        else $error("add did not complete in one cycle");

endmodule

[design/rrc_cell.sv]
// One cell of the sorted block chain: holds a block, shifts on insert, rotates on scan.
module rrc_cell
    import rrc_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW = 6
)
(
    input  logic       clk,
    input  cell_cmd_t  cmd,
    input  logic [CW-1:0] count,
    input  cell_data_t left,
    input  logic       left_ins,
    input  cell_data_t right,
    input  cell_data_t head,
    output logic       ins,
    output cell_data_t q
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);
    localparam logic [CW:0] NEXT_IDX = (CW+1)'(IDX + 1);

    cell_data_t data_reg;
    cell_data_t data_next;
    logic       occupied;
    logic       take_left;

    assign occupied = MY_IDX < count;
    // This cell sits at or after the insertion point of the new block.
    assign ins = (occupied && (data_reg.pos > cmd.new_pos)) || (MY_IDX == count);
    assign take_left = (IDX > 0) && left_ins;
    assign q = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert && ins)
        begin
            if (take_left)
            begin
                data_next = left;
            end
            else
            begin
                data_next.pos = cmd.new_pos;
                data_next.len = cmd.new_len;
                data_next.off = data_reg.off;
            end
        end
        else if (cmd.rotate)
        begin
            if (NEXT_IDX < {1'b0, count})
            begin
                data_next = right;
            end
            else if (NEXT_IDX == {1'b0, count})
            begin
                data_next = head;
                if (cmd.wr_off)
                begin
                    data_next.off = cmd.new_off;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
